// ===== hdl/dpc_pkg.sv =====
package dpc_pkg;

    localparam int FRAC_BITS = 16;
    localparam logic [31:0] MIN_SPEED_RESET =
        32'(((64'd1 << (2 * FRAC_BITS)) + 64'd50000) / 64'd100000);

    localparam logic ADDR_MIN_SPEED = 1'b0;

    localparam int VEL_W      = 32;
    localparam int RAD_W      = 31;
    localparam int MAG_W      = 33;
    localparam int SUM_W      = 32;
    localparam int MUL_W      = 68;
    localparam int CHUNK_W    = 17;
    localparam int MUL_STAGES = MUL_W / CHUNK_W;
    localparam int PP_W       = MUL_W + CHUNK_W;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int SQ_W       = 66;
    localparam int CMP_W      = 132;
    localparam int K_W        = 64;
    localparam int N_W        = 129;
    localparam int D_W        = 97;
    localparam int DEN_W      = D_W + 1;
    localparam int NUM_W      = 132;
    localparam int Q_W        = 36;
    localparam int IMP_W      = 39;
    localparam int PIPE_LAT   = 3 * MUL_STAGES + 3 + Q_W;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    localparam logic signed [VEL_W-1:0] VEL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [VEL_W-1:0] VEL_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic signed [VEL_W-1:0] a_pos_x;
        logic signed [VEL_W-1:0] a_pos_y;
        logic signed [VEL_W-1:0] a_vel_x;
        logic signed [VEL_W-1:0] a_vel_y;
        logic [RAD_W-1:0]        a_radius;
        logic signed [VEL_W-1:0] b_pos_x;
        logic signed [VEL_W-1:0] b_pos_y;
        logic signed [VEL_W-1:0] b_vel_x;
        logic signed [VEL_W-1:0] b_vel_y;
        logic [RAD_W-1:0]        b_radius;
    } t_in_word;

    typedef struct packed {
        logic                    collided;
        logic signed [VEL_W-1:0] new_a_vel_x;
        logic signed [VEL_W-1:0] new_a_vel_y;
        logic signed [VEL_W-1:0] new_b_vel_x;
        logic signed [VEL_W-1:0] new_b_vel_y;
    } t_out_word;

    typedef struct packed {
        logic [MAG_W-1:0]        sxm;
        logic                    sx_neg;
        logic [MAG_W-1:0]        sym;
        logic                    sy_neg;
        logic [MAG_W-1:0]        vxm;
        logic                    vx_neg;
        logic [MAG_W-1:0]        vym;
        logic                    vy_neg;
        logic [SUM_W-1:0]        rs;
        logic [RAD_W-1:0]        ma;
        logic [RAD_W-1:0]        mb;
        logic signed [VEL_W-1:0] avx;
        logic signed [VEL_W-1:0] avy;
        logic signed [VEL_W-1:0] bvx;
        logic signed [VEL_W-1:0] bvy;
    } t_front_word;

    function automatic logic [MAG_W-1:0] f_mag(logic signed [MAG_W-1:0] x);
        return x[MAG_W-1] ? MAG_W'(-x) : MAG_W'(x);
    endfunction

    // v plus or minus q, saturated
    function automatic logic signed [VEL_W-1:0] f_apply(logic signed [VEL_W-1:0] v,
                                                        logic [Q_W-1:0] q,
                                                        logic minus);
        logic signed [IMP_W-1:0] ve;
        logic signed [IMP_W-1:0] qe;
        logic signed [IMP_W-1:0] s;
        ve = IMP_W'(v);
        qe = $signed(IMP_W'(q));
        s  = minus ? ve - qe : ve + qe;
        if (s[IMP_W-1:VEL_W-1] == '0 || s[IMP_W-1:VEL_W-1] == '1) begin
            return s[VEL_W-1:0];
        end
        return s[IMP_W-1] ? VEL_MIN : VEL_MAX;
    endfunction

endpackage

// ===== hdl/dpc_front.sv =====
module dpc_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  dpc_pkg::t_in_word    i_item,
    input  logic                 i_q_full,
    output logic                 o_busy,
    output logic                 o_push,
    output dpc_pkg::t_front_word o_word
);

    logic                 r_valid;
    logic                 n_valid;
    dpc_pkg::t_front_word r_word;
    dpc_pkg::t_front_word w_word;
    logic                 w_accept;
    logic signed [dpc_pkg::MAG_W-1:0] w_sx;
    logic signed [dpc_pkg::MAG_W-1:0] w_sy;
    logic signed [dpc_pkg::MAG_W-1:0] w_vx;
    logic signed [dpc_pkg::MAG_W-1:0] w_vy;

    assign o_busy   = r_valid & i_q_full;
    assign o_push   = r_valid & ~i_q_full;
    assign o_word   = r_word;
    assign w_accept = i_start & ~o_busy;
    assign n_valid  = w_accept | (r_valid & i_q_full);

    // center offset and relative velocity as sign and magnitude
    always_comb begin
        w_sx = dpc_pkg::MAG_W'(i_item.a_pos_x) - dpc_pkg::MAG_W'(i_item.b_pos_x);
        w_sy = dpc_pkg::MAG_W'(i_item.a_pos_y) - dpc_pkg::MAG_W'(i_item.b_pos_y);
        w_vx = dpc_pkg::MAG_W'(i_item.a_vel_x) - dpc_pkg::MAG_W'(i_item.b_vel_x);
        w_vy = dpc_pkg::MAG_W'(i_item.a_vel_y) - dpc_pkg::MAG_W'(i_item.b_vel_y);
        w_word.sxm    = dpc_pkg::f_mag(w_sx);
        w_word.sx_neg = w_sx[dpc_pkg::MAG_W-1];
        w_word.sym    = dpc_pkg::f_mag(w_sy);
        w_word.sy_neg = w_sy[dpc_pkg::MAG_W-1];
        w_word.vxm    = dpc_pkg::f_mag(w_vx);
        w_word.vx_neg = w_vx[dpc_pkg::MAG_W-1];
        w_word.vym    = dpc_pkg::f_mag(w_vy);
        w_word.vy_neg = w_vy[dpc_pkg::MAG_W-1];
        w_word.rs     = dpc_pkg::SUM_W'(i_item.a_radius) + dpc_pkg::SUM_W'(i_item.b_radius);
        w_word.ma     = i_item.a_radius;
        w_word.mb     = i_item.b_radius;
        w_word.avx    = i_item.a_vel_x;
        w_word.avy    = i_item.a_vel_y;
        w_word.bvx    = i_item.b_vel_x;
        w_word.bvy    = i_item.b_vel_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_word <= w_word;
        end
    end

endmodule

// ===== hdl/dpc_fifo.sv =====
module dpc_fifo (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  dpc_pkg::t_front_word i_word,
    output logic                 o_full,
    output logic                 o_valid,
    output dpc_pkg::t_front_word o_word
);

    dpc_pkg::t_front_word             r_mem [dpc_pkg::Q_DEPTH];
    logic [dpc_pkg::Q_PTR_W-1:0]      r_wp;
    logic [dpc_pkg::Q_PTR_W-1:0]      r_rp;
    logic [dpc_pkg::Q_CNT_W-1:0]      r_cnt;
    logic [dpc_pkg::Q_CNT_W-1:0]      n_cnt;
    logic                             w_pop;

    // the back end never stalls, so any held word is taken at once
    assign o_valid = r_cnt != '0;
    assign w_pop   = o_valid;
    assign o_full  = r_cnt == dpc_pkg::Q_CNT_W'(dpc_pkg::Q_DEPTH);
    assign o_word  = r_mem[r_rp];

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !w_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && w_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= r_rp + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_word;
        end
    end

endmodule

// ===== hdl/dpc_mul.sv =====
module dpc_mul (
    input  logic                        i_clk,
    input  logic [dpc_pkg::MUL_W-1:0]  i_a,
    input  logic [dpc_pkg::MUL_W-1:0]  i_b,
    output logic [dpc_pkg::PROD_W-1:0] o_p
);

    logic [dpc_pkg::MUL_W-1:0]  r_a   [dpc_pkg::MUL_STAGES-1];
    logic [dpc_pkg::MUL_W-1:0]  r_b   [dpc_pkg::MUL_STAGES-1];
    logic [dpc_pkg::PROD_W-1:0] r_acc [dpc_pkg::MUL_STAGES];
    logic [dpc_pkg::PP_W-1:0]   w_pp  [dpc_pkg::MUL_STAGES];

    // one chunk of b per stage
    always_comb begin
        w_pp[0] = dpc_pkg::PP_W'(i_a) * dpc_pkg::PP_W'(i_b[dpc_pkg::CHUNK_W-1:0]);
        for (int k = 1; k < dpc_pkg::MUL_STAGES; k++) begin
            w_pp[k] = dpc_pkg::PP_W'(r_a[k-1])
                    * dpc_pkg::PP_W'(r_b[k-1][k*dpc_pkg::CHUNK_W +: dpc_pkg::CHUNK_W]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_a[0]   <= i_a;
        r_b[0]   <= i_b;
        r_acc[0] <= dpc_pkg::PROD_W'(w_pp[0]);
        for (int k = 1; k < dpc_pkg::MUL_STAGES - 1; k++) begin
            r_a[k] <= r_a[k-1];
            r_b[k] <= r_b[k-1];
        end
        for (int k = 1; k < dpc_pkg::MUL_STAGES; k++) begin
            r_acc[k] <= r_acc[k-1] + (dpc_pkg::PROD_W'(w_pp[k]) << (k * dpc_pkg::CHUNK_W));
        end
    end

    assign o_p = r_acc[dpc_pkg::MUL_STAGES-1];

endmodule

// ===== hdl/dpc_div.sv =====
module dpc_div (
    input  logic                       i_clk,
    input  logic [dpc_pkg::NUM_W-1:0] i_num,
    input  logic [dpc_pkg::DEN_W-1:0] i_den,
    output logic [dpc_pkg::Q_W-1:0]   o_q
);

    logic [dpc_pkg::DEN_W-1:0] r_rem  [dpc_pkg::Q_W];
    logic [dpc_pkg::DEN_W-1:0] r_den  [dpc_pkg::Q_W];
    logic [dpc_pkg::Q_W-1:0]   r_bits [dpc_pkg::Q_W];
    logic [dpc_pkg::Q_W-1:0]   r_q    [dpc_pkg::Q_W];
    logic [dpc_pkg::DEN_W-1:0] w_rem  [dpc_pkg::Q_W];
    logic [dpc_pkg::DEN_W-1:0] w_den  [dpc_pkg::Q_W];
    logic [dpc_pkg::Q_W-1:0]   w_bits [dpc_pkg::Q_W];
    logic [dpc_pkg::Q_W-1:0]   w_q    [dpc_pkg::Q_W];
    logic [dpc_pkg::DEN_W:0]   w_t    [dpc_pkg::Q_W];
    logic                      w_ge   [dpc_pkg::Q_W];

    // restoring division, one quotient bit per stage
    always_comb begin
        w_rem[0]  = dpc_pkg::DEN_W'(i_num[dpc_pkg::NUM_W-1:dpc_pkg::Q_W]);
        w_den[0]  = i_den;
        w_bits[0] = i_num[dpc_pkg::Q_W-1:0];
        w_q[0]    = '0;
        for (int k = 1; k < dpc_pkg::Q_W; k++) begin
            w_rem[k]  = r_rem[k-1];
            w_den[k]  = r_den[k-1];
            w_bits[k] = r_bits[k-1];
            w_q[k]    = r_q[k-1];
        end
        for (int k = 0; k < dpc_pkg::Q_W; k++) begin
            w_t[k]  = {w_rem[k], w_bits[k][dpc_pkg::Q_W-1]};
            w_ge[k] = w_t[k] >= {1'b0, w_den[k]};
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < dpc_pkg::Q_W; k++) begin
            r_rem[k]  <= w_ge[k] ? dpc_pkg::DEN_W'(w_t[k] - {1'b0, w_den[k]})
                                 : dpc_pkg::DEN_W'(w_t[k]);
            r_den[k]  <= w_den[k];
            r_bits[k] <= w_bits[k] << 1;
            r_q[k]    <= {w_q[k][dpc_pkg::Q_W-2:0], w_ge[k]};
        end
    end

    assign o_q = r_q[dpc_pkg::Q_W-1];

endmodule

// ===== hdl/dpc_back.sv =====
module dpc_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [31:0]          i_min_speed,
    input  logic                 i_valid,
    input  dpc_pkg::t_front_word i_word,
    output logic                 o_valid,
    output dpc_pkg::t_out_word   o_result
);

    typedef struct packed {
        logic [dpc_pkg::SQ_W-1:0] ss;
        logic [dpc_pkg::SQ_W-1:0] a1;
        logic [dpc_pkg::SQ_W-1:0] c1;
        logic [dpc_pkg::SQ_W-1:0] b1m;
        logic                     b1n;
        logic                     ovl;
        logic                     a1ok;
        dpc_pkg::t_front_word     fw;
    } t_stage_b;

    typedef struct packed {
        logic [dpc_pkg::SQ_W-1:0]         b1m;
        logic                             b1n;
        logic                             ovl;
        logic                             a1ok;
        logic                             sx_neg;
        logic                             sy_neg;
        logic signed [dpc_pkg::VEL_W-1:0] avx;
        logic signed [dpc_pkg::VEL_W-1:0] avy;
        logic signed [dpc_pkg::VEL_W-1:0] bvx;
        logic signed [dpc_pkg::VEL_W-1:0] bvy;
    } t_side_c;

    typedef struct packed {
        logic                             upd;
        logic                             hit;
        logic                             neg_x;
        logic                             neg_y;
        logic signed [dpc_pkg::VEL_W-1:0] avx;
        logic signed [dpc_pkg::VEL_W-1:0] avy;
        logic signed [dpc_pkg::VEL_W-1:0] bvx;
        logic signed [dpc_pkg::VEL_W-1:0] bvy;
    } t_side_g;

    typedef struct packed {
        logic [dpc_pkg::DEN_W-1:0] den;
        logic [dpc_pkg::K_W-1:0]   kax;
        logic [dpc_pkg::K_W-1:0]   kay;
        logic [dpc_pkg::K_W-1:0]   kbx;
        logic [dpc_pkg::K_W-1:0]   kby;
        logic [dpc_pkg::SQ_W-1:0]  b1m;
        t_side_g                   sg;
    } t_stage_d;

    typedef struct packed {
        logic [dpc_pkg::DEN_W-1:0] den;
        t_side_g                   sg;
    } t_side_e;

    typedef struct packed {
        logic [dpc_pkg::NUM_W-1:0] nax;
        logic [dpc_pkg::NUM_W-1:0] nay;
        logic [dpc_pkg::NUM_W-1:0] nbx;
        logic [dpc_pkg::NUM_W-1:0] nby;
        logic [dpc_pkg::DEN_W-1:0] den;
        t_side_g                   sg;
    } t_stage_f;

    logic [dpc_pkg::PIPE_LAT-1:0] r_vld;
    dpc_pkg::t_front_word         r_fw_a [dpc_pkg::MUL_STAGES];
    t_stage_b                     r_b;
    t_stage_b                     w_b;
    t_side_c                      r_sc   [dpc_pkg::MUL_STAGES];
    t_side_c                      w_sc;
    t_stage_d                     r_d;
    t_stage_d                     w_d;
    t_side_e                      r_se   [dpc_pkg::MUL_STAGES];
    t_stage_f                     r_f;
    t_stage_f                     w_f;
    t_side_g                      r_sg   [dpc_pkg::Q_W];
    t_side_g                      w_g;
    logic                         r_out_valid;
    dpc_pkg::t_out_word           r_out;
    dpc_pkg::t_out_word           w_out;

    logic [dpc_pkg::PROD_W-1:0] p_sxx, p_syy, p_vsx, p_vsy, p_vxx, p_vyy, p_rr;
    logic [dpc_pkg::PROD_W-1:0] p_bb, p_ac, p_d, p_kax, p_kay, p_kbx, p_kby;
    logic [dpc_pkg::PROD_W-1:0] p_nax, p_nay, p_nbx, p_nby;
    logic [dpc_pkg::Q_W-1:0]    q_ax, q_ay, q_bx, q_by;
    logic [dpc_pkg::SQ_W-1:0]   w_rr, w_tx, w_ty;
    logic                       w_txn, w_tyn;
    logic [dpc_pkg::D_W-1:0]    w_dd;

    // squares and dot products
    dpc_mul u_mul_sxx (.i_clk, .i_a(dpc_pkg::MUL_W'(i_word.sxm)),
                       .i_b(dpc_pkg::MUL_W'(i_word.sxm)), .o_p(p_sxx));
    dpc_mul u_mul_syy (.i_clk, .i_a(dpc_pkg::MUL_W'(i_word.sym)),
                       .i_b(dpc_pkg::MUL_W'(i_word.sym)), .o_p(p_syy));
    dpc_mul u_mul_vsx (.i_clk, .i_a(dpc_pkg::MUL_W'(i_word.vxm)),
                       .i_b(dpc_pkg::MUL_W'(i_word.sxm)), .o_p(p_vsx));
    dpc_mul u_mul_vsy (.i_clk, .i_a(dpc_pkg::MUL_W'(i_word.vym)),
                       .i_b(dpc_pkg::MUL_W'(i_word.sym)), .o_p(p_vsy));
    dpc_mul u_mul_vxx (.i_clk, .i_a(dpc_pkg::MUL_W'(i_word.vxm)),
                       .i_b(dpc_pkg::MUL_W'(i_word.vxm)), .o_p(p_vxx));
    dpc_mul u_mul_vyy (.i_clk, .i_a(dpc_pkg::MUL_W'(i_word.vym)),
                       .i_b(dpc_pkg::MUL_W'(i_word.vym)), .o_p(p_vyy));
    dpc_mul u_mul_rr  (.i_clk, .i_a(dpc_pkg::MUL_W'(i_word.rs)),
                       .i_b(dpc_pkg::MUL_W'(i_word.rs)), .o_p(p_rr));

    always_comb begin
        w_b.fw   = r_fw_a[dpc_pkg::MUL_STAGES-1];
        w_b.ss   = p_sxx[dpc_pkg::SQ_W-1:0] + p_syy[dpc_pkg::SQ_W-1:0];
        w_b.a1   = p_vxx[dpc_pkg::SQ_W-1:0] + p_vyy[dpc_pkg::SQ_W-1:0];
        w_rr     = p_rr[dpc_pkg::SQ_W-1:0];
        w_b.ovl  = w_b.ss < w_rr;
        w_b.c1   = w_b.ss - w_rr;
        w_b.a1ok = w_b.a1 >= dpc_pkg::SQ_W'(i_min_speed);
        w_tx     = p_vsx[dpc_pkg::SQ_W-1:0];
        w_ty     = p_vsy[dpc_pkg::SQ_W-1:0];
        w_txn    = w_b.fw.vx_neg ^ w_b.fw.sx_neg;
        w_tyn    = w_b.fw.vy_neg ^ w_b.fw.sy_neg;
        if (w_txn == w_tyn) begin
            w_b.b1m = w_tx + w_ty;
            w_b.b1n = w_txn;
        end else if (w_tx >= w_ty) begin
            w_b.b1m = w_tx - w_ty;
            w_b.b1n = w_txn;
        end else begin
            w_b.b1m = w_ty - w_tx;
            w_b.b1n = w_tyn;
        end
    end

    // discriminant terms, impulse denominator, mass times offset
    dpc_mul u_mul_bb  (.i_clk, .i_a(dpc_pkg::MUL_W'(r_b.b1m)),
                       .i_b(dpc_pkg::MUL_W'(r_b.b1m)), .o_p(p_bb));
    dpc_mul u_mul_ac  (.i_clk, .i_a(dpc_pkg::MUL_W'(r_b.a1)),
                       .i_b(dpc_pkg::MUL_W'(r_b.c1)), .o_p(p_ac));
    dpc_mul u_mul_d   (.i_clk, .i_a(dpc_pkg::MUL_W'(r_b.fw.rs)),
                       .i_b(dpc_pkg::MUL_W'(r_b.ss)), .o_p(p_d));
    dpc_mul u_mul_kax (.i_clk, .i_a(dpc_pkg::MUL_W'({r_b.fw.mb, 1'b0})),
                       .i_b(dpc_pkg::MUL_W'(r_b.fw.sxm)), .o_p(p_kax));
    dpc_mul u_mul_kay (.i_clk, .i_a(dpc_pkg::MUL_W'({r_b.fw.mb, 1'b0})),
                       .i_b(dpc_pkg::MUL_W'(r_b.fw.sym)), .o_p(p_kay));
    dpc_mul u_mul_kbx (.i_clk, .i_a(dpc_pkg::MUL_W'({r_b.fw.ma, 1'b0})),
                       .i_b(dpc_pkg::MUL_W'(r_b.fw.sxm)), .o_p(p_kbx));
    dpc_mul u_mul_kby (.i_clk, .i_a(dpc_pkg::MUL_W'({r_b.fw.ma, 1'b0})),
                       .i_b(dpc_pkg::MUL_W'(r_b.fw.sym)), .o_p(p_kby));

    always_comb begin
        w_sc.b1m    = r_b.b1m;
        w_sc.b1n    = r_b.b1n;
        w_sc.ovl    = r_b.ovl;
        w_sc.a1ok   = r_b.a1ok;
        w_sc.sx_neg = r_b.fw.sx_neg;
        w_sc.sy_neg = r_b.fw.sy_neg;
        w_sc.avx    = r_b.fw.avx;
        w_sc.avy    = r_b.fw.avy;
        w_sc.bvx    = r_b.fw.bvx;
        w_sc.bvy    = r_b.fw.bvy;
    end

    always_comb begin
        w_dd         = p_d[dpc_pkg::D_W-1:0];
        w_d.sg.hit   = r_sc[dpc_pkg::MUL_STAGES-1].ovl
                     | (r_sc[dpc_pkg::MUL_STAGES-1].a1ok & r_sc[dpc_pkg::MUL_STAGES-1].b1n
                        & (r_sc[dpc_pkg::MUL_STAGES-1].b1m != '0)
                        & (p_bb[dpc_pkg::CMP_W-1:0] >= p_ac[dpc_pkg::CMP_W-1:0]));
        w_d.sg.upd   = w_d.sg.hit & (w_dd != '0);
        w_d.sg.neg_x = r_sc[dpc_pkg::MUL_STAGES-1].sx_neg ^ r_sc[dpc_pkg::MUL_STAGES-1].b1n;
        w_d.sg.neg_y = r_sc[dpc_pkg::MUL_STAGES-1].sy_neg ^ r_sc[dpc_pkg::MUL_STAGES-1].b1n;
        w_d.sg.avx   = r_sc[dpc_pkg::MUL_STAGES-1].avx;
        w_d.sg.avy   = r_sc[dpc_pkg::MUL_STAGES-1].avy;
        w_d.sg.bvx   = r_sc[dpc_pkg::MUL_STAGES-1].bvx;
        w_d.sg.bvy   = r_sc[dpc_pkg::MUL_STAGES-1].bvy;
        w_d.den      = {w_dd, 1'b0};
        w_d.kax      = p_kax[dpc_pkg::K_W-1:0];
        w_d.kay      = p_kay[dpc_pkg::K_W-1:0];
        w_d.kbx      = p_kbx[dpc_pkg::K_W-1:0];
        w_d.kby      = p_kby[dpc_pkg::K_W-1:0];
        w_d.b1m      = r_sc[dpc_pkg::MUL_STAGES-1].b1m;
    end

    // impulse numerators
    dpc_mul u_mul_nax (.i_clk, .i_a(dpc_pkg::MUL_W'(r_d.kax)),
                       .i_b(dpc_pkg::MUL_W'(r_d.b1m)), .o_p(p_nax));
    dpc_mul u_mul_nay (.i_clk, .i_a(dpc_pkg::MUL_W'(r_d.kay)),
                       .i_b(dpc_pkg::MUL_W'(r_d.b1m)), .o_p(p_nay));
    dpc_mul u_mul_nbx (.i_clk, .i_a(dpc_pkg::MUL_W'(r_d.kbx)),
                       .i_b(dpc_pkg::MUL_W'(r_d.b1m)), .o_p(p_nbx));
    dpc_mul u_mul_nby (.i_clk, .i_a(dpc_pkg::MUL_W'(r_d.kby)),
                       .i_b(dpc_pkg::MUL_W'(r_d.b1m)), .o_p(p_nby));

    // round half away: (2n + d) / 2d
    always_comb begin
        w_f.den = r_se[dpc_pkg::MUL_STAGES-1].den;
        w_f.sg  = r_se[dpc_pkg::MUL_STAGES-1].sg;
        w_f.nax = dpc_pkg::NUM_W'({p_nax[dpc_pkg::N_W-1:0], 1'b0})
                + dpc_pkg::NUM_W'(w_f.den[dpc_pkg::DEN_W-1:1]);
        w_f.nay = dpc_pkg::NUM_W'({p_nay[dpc_pkg::N_W-1:0], 1'b0})
                + dpc_pkg::NUM_W'(w_f.den[dpc_pkg::DEN_W-1:1]);
        w_f.nbx = dpc_pkg::NUM_W'({p_nbx[dpc_pkg::N_W-1:0], 1'b0})
                + dpc_pkg::NUM_W'(w_f.den[dpc_pkg::DEN_W-1:1]);
        w_f.nby = dpc_pkg::NUM_W'({p_nby[dpc_pkg::N_W-1:0], 1'b0})
                + dpc_pkg::NUM_W'(w_f.den[dpc_pkg::DEN_W-1:1]);
    end

    dpc_div u_div_ax (.i_clk, .i_num(r_f.nax), .i_den(r_f.den), .o_q(q_ax));
    dpc_div u_div_ay (.i_clk, .i_num(r_f.nay), .i_den(r_f.den), .o_q(q_ay));
    dpc_div u_div_bx (.i_clk, .i_num(r_f.nbx), .i_den(r_f.den), .o_q(q_bx));
    dpc_div u_div_by (.i_clk, .i_num(r_f.nby), .i_den(r_f.den), .o_q(q_by));

    always_comb begin
        w_g            = r_sg[dpc_pkg::Q_W-1];
        w_out.collided = w_g.hit;
        if (w_g.upd) begin
            w_out.new_a_vel_x = dpc_pkg::f_apply(w_g.avx, q_ax, ~w_g.neg_x);
            w_out.new_a_vel_y = dpc_pkg::f_apply(w_g.avy, q_ay, ~w_g.neg_y);
            w_out.new_b_vel_x = dpc_pkg::f_apply(w_g.bvx, q_bx, w_g.neg_x);
            w_out.new_b_vel_y = dpc_pkg::f_apply(w_g.bvy, q_by, w_g.neg_y);
        end else begin
            w_out.new_a_vel_x = w_g.avx;
            w_out.new_a_vel_y = w_g.avy;
            w_out.new_b_vel_x = w_g.bvx;
            w_out.new_b_vel_y = w_g.bvy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fw_a[0] <= i_word;
        r_sc[0]   <= w_sc;
        r_se[0]   <= '{den: r_d.den, sg: r_d.sg};
        for (int k = 1; k < dpc_pkg::MUL_STAGES; k++) begin
            r_fw_a[k] <= r_fw_a[k-1];
            r_sc[k]   <= r_sc[k-1];
            r_se[k]   <= r_se[k-1];
        end
        r_sg[0] <= r_f.sg;
        for (int k = 1; k < dpc_pkg::Q_W; k++) begin
            r_sg[k] <= r_sg[k-1];
        end
        r_b   <= w_b;
        r_d   <= w_d;
        r_f   <= w_f;
        r_out <= w_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_vld       <= {r_vld[dpc_pkg::PIPE_LAT-2:0], i_valid};
            r_out_valid <= r_vld[dpc_pkg::PIPE_LAT-1];
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

// ===== hdl/disc_pair_collide_and_bounce.sv =====
// channel   | handshake                          | payload
// ----------+------------------------------------+---------------------
// item in   | start, busy (taken on start & !busy)| i_item (t_in_word)
// result    | o_strobe, one cycle, no backpressure| o_result (t_out_word)
// register  | apb psel/penable/pwrite, pready = 1 | pwdata, prdata
//
// one word per cycle while busy is low
// the back end is built from three 4-stage multiplier rows and the 36-stage divider
// busy rises only if the front register meets a full queue
// synchronous reset clears valid bits and queue pointers and loads the threshold reset value
module disc_pair_collide_and_bounce (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  dpc_pkg::t_in_word  i_item,
    output logic               o_strobe,
    output dpc_pkg::t_out_word o_result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic                 r_min_speed;
    logic [31:0]          r_min_speed_val;
    logic                 w_wr;
    logic                 w_push;
    logic                 w_q_full;
    logic                 w_q_valid;
    dpc_pkg::t_front_word w_front_word;
    dpc_pkg::t_front_word w_q_word;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite & pready & (paddr[2] == dpc_pkg::ADDR_MIN_SPEED);
    assign prdata = (paddr[2] == dpc_pkg::ADDR_MIN_SPEED) ? r_min_speed_val : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_speed_val <= dpc_pkg::MIN_SPEED_RESET;
            r_min_speed     <= 1'b0;
        end else begin
            r_min_speed <= w_wr;
            if (w_wr) begin
                r_min_speed_val <= pwdata;
            end
        end
    end

    dpc_front u_front (
        .i_clk,
        .i_rst_n,
        .i_start  (start),
        .i_item,
        .i_q_full (w_q_full),
        .o_busy   (busy),
        .o_push   (w_push),
        .o_word   (w_front_word)
    );

    dpc_fifo u_fifo (
        .i_clk,
        .i_rst_n,
        .i_push  (w_push),
        .i_word  (w_front_word),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_word  (w_q_word)
    );

    dpc_back u_back (
        .i_clk,
        .i_rst_n,
        .i_min_speed (r_min_speed_val),
        .i_valid     (w_q_valid),
        .i_word      (w_q_word),
        .o_valid     (o_strobe),
        .o_result
    );

`ifndef NO_ASSERTIONS
    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n) !busy)
        else $error("queue filled while back end drains every cycle");

    a_reg_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_min_speed |-> r_min_speed_val == $past(pwdata))
        else $error("threshold register lost a write");
`endif

endmodule
